>>> rtl/core/b64e_pkg.sv
// Shared types, constants and the character mapping function for the base64url encoder.
`timescale 1ns / 1ps
package b64e_pkg;

   // Zero-based held-byte count when a group is flushed: 0, 1 or 2 held
   localparam logic [1:0] HELD_NONE = 2'd0;
   localparam logic [1:0] HELD_ONE  = 2'd1;
   localparam logic [1:0] HELD_TWO  = 2'd2;

   // Character slots within one output group
   localparam logic [1:0] SLOT_FIRST  = 2'd0;
   localparam logic [1:0] SLOT_SECOND = 2'd1;
   localparam logic [1:0] SLOT_THIRD  = 2'd2;
   localparam logic [1:0] SLOT_FOURTH = 2'd3;

   localparam logic [6:0] PAD_CHAR = 7'h3D;

   // Group queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One flushed group: three bytes (zero filled), bytes held before it, final flag
   typedef struct packed {
      logic [23:0] bits;
      logic [1:0]  held;
      logic        fin;
   } group_type;

   // Push side of the group queue
   typedef struct packed {
      logic      valid;
      group_type group;
   } push_type;

   // Map a six-bit value to its URL-safe alphabet character
   function automatic logic [6:0] encode_sextet(input logic [5:0] v);
      logic [6:0] ch;
      if (v < 6'd26) begin
         ch = 7'h41 + {1'b0, v};
      end else if (v < 6'd52) begin
         ch = 7'h61 + {1'b0, v - 6'd26};
      end else if (v < 6'd62) begin
         ch = 7'h30 + {1'b0, v - 6'd52};
      end else if (v == 6'd62) begin
         ch = 7'h2D;
      end else begin
         ch = 7'h5F;
      end
      return ch;
   endfunction

endpackage

>>> rtl/core/b64e_if.sv
// Valid/ready channel interfaces for the encoder's byte input and character output.
`timescale 1ns / 1ps
interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       run_last;
   logic       message_end;

   modport source (output valid, output out_char, output run_last, output message_end,
                   input ready);
   modport sink   (input valid, input out_char, input run_last, input message_end,
                   output ready);
endinterface

>>> rtl/core/b64e_front.sv
// Front end: gathers input bytes into groups and pushes completed groups to the queue.
`timescale 1ns / 1ps
module b64e_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        in_byte,
   input  logic              in_final,
   input  logic              queue_full,
   output b64e_pkg::push_type push
);
   import b64e_pkg::*;

   logic [15:0] pending_ff, pending_in;
   logic [1:0]  count_ff, count_in;
   logic [1:0]  held;
   logic        accept;
   logic        flush;

   // Take a byte whenever the queue can absorb a possible flush
   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   // Treat an impossible count of three as empty
   assign held  = (count_ff == 2'd3) ? HELD_NONE : count_ff;
   assign flush = in_final || (held == HELD_TWO);

   // Assemble the zero-filled group and decide the next holding state
   always_comb begin
      push.valid      = accept && flush;
      push.group.held = held;
      push.group.fin  = in_final;
      unique case (held)
         HELD_TWO: push.group.bits = {pending_ff, in_byte};
         HELD_ONE: push.group.bits = {pending_ff[7:0], in_byte, 8'h00};
         default:  push.group.bits = {in_byte, 16'h0000};
      endcase

      pending_in = pending_ff;
      count_in   = count_ff;
      if (accept) begin
         if (flush) begin
            pending_in = 16'h0000;
            count_in   = HELD_NONE;
         end else begin
            pending_in = {pending_ff[7:0], in_byte};
            count_in   = held + 2'd1;
         end
      end
   end

   // Hold pending bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 16'h0000;
         count_ff   <= HELD_NONE;
      end else begin
         pending_ff <= pending_in;
         count_ff   <= count_in;
      end
   end

endmodule

>>> rtl/core/b64e_queue.sv
// Short FIFO of flushed groups between the front and back ends.
`timescale 1ns / 1ps
module b64e_queue (
   input  logic                clock,
   input  logic                reset,
   input  b64e_pkg::push_type  push,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output b64e_pkg::group_type head
);
   import b64e_pkg::*;

   group_type               entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];
   assign do_push   = push.valid && !full;
   assign do_pop    = pop && not_empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed groups
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.group;
      end
   end

endmodule

>>> rtl/core/b64e_back.sv
// Back end: expands each queued group into four characters, one per cycle while the output is ready.
`timescale 1ns / 1ps
module b64e_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_not_empty,
   input  b64e_pkg::group_type queue_head,
   output logic                queue_pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [6:0]          out_char,
   output logic                out_run_last,
   output logic                out_message_end
);
   import b64e_pkg::*;

   group_type  group_ff, group_in;
   logic       active_ff, active_in;
   logic [1:0] slot_ff, slot_in;
   logic       valid_ff, valid_in;
   logic [6:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       end_ff, end_in;
   logic       emit;
   logic       group_done;
   logic [5:0] sextet;
   logic       pad;

   // Send a character when one is in hand and the output register frees up
   assign emit       = active_ff && (!valid_ff || out_ready);
   assign group_done = emit && (slot_ff == SLOT_FOURTH);
   assign queue_pop  = queue_not_empty && (!active_ff || group_done);

   // Pick the sextet and padding for the current slot
   always_comb begin
      pad = 1'b0;
      unique case (slot_ff)
         SLOT_FIRST:  sextet = group_ff.bits[23:18];
         SLOT_SECOND: sextet = group_ff.bits[17:12];
         SLOT_THIRD: begin
            sextet = group_ff.bits[11:6];
            pad    = (group_ff.held == HELD_NONE);
         end
         default: begin
            sextet = group_ff.bits[5:0];
            pad    = (group_ff.held != HELD_TWO);
         end
      endcase
   end

   // Step through slots and load the output register
   always_comb begin
      group_in  = group_ff;
      active_in = active_ff;
      slot_in   = slot_ff;
      valid_in  = valid_ff && !out_ready;
      char_in   = char_ff;
      last_in   = last_ff;
      end_in    = end_ff;

      if (emit) begin
         valid_in = 1'b1;
         char_in  = pad ? PAD_CHAR : encode_sextet(sextet);
         last_in  = (slot_ff == SLOT_FOURTH);
         end_in   = (slot_ff == SLOT_FOURTH) && group_ff.fin;
         slot_in  = slot_ff + 2'd1;
         if (group_done) begin
            active_in = 1'b0;
         end
      end

      if (queue_pop) begin
         group_in  = queue_head;
         active_in = 1'b1;
         slot_in   = SLOT_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         slot_ff   <= SLOT_FIRST;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         slot_ff   <= slot_in;
         valid_ff  <= valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      group_ff <= group_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
      end_ff   <= end_in;
   end

   assign out_valid       = valid_ff;
   assign out_char        = char_ff;
   assign out_run_last    = last_ff;
   assign out_message_end = end_ff;

endmodule

>>> rtl/core/base64url_padded_encoder_unit.sv
// Top level of the URL-safe base64 encoder with '=' padding.
`timescale 1ns / 1ps
// Bytes enter on req_if, one per transfer, with final_byte marking the last byte of a
// message; characters leave on rsp_if, one per transfer, from the alphabet A-Z a-z 0-9
// '-' '_' or the pad '='. Every third byte, and every final byte, closes a group that
// yields exactly four characters; run_last flags the fourth and message_end flags it
// too when the group closed a message. The front end accepts a byte in every cycle
// while its two-entry group queue has room; the back end sends one character per cycle
// from its output register while the receiver is ready, so it sends four characters for
// every three bytes. The byte that closes a group passes through the queue entry, the back
// end's group register and the output register before its first character is offered.
module base64url_padded_encoder_unit (
   input logic clock,
   input logic reset,
   b64e_req_if.sink   req_if,
   b64e_rsp_if.source rsp_if
);
   import b64e_pkg::*;

   push_type  push;
   group_type head;
   logic      queue_full;
   logic      queue_not_empty;
   logic      queue_pop;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_if.valid),
      .in_ready   (req_if.ready),
      .in_byte    (req_if.data_byte),
      .in_final   (req_if.final_byte),
      .queue_full (queue_full),
      .push       (push)
   );

   b64e_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .head      (head)
   );

   b64e_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .queue_head      (head),
      .queue_pop       (queue_pop),
      .out_valid       (rsp_if.valid),
      .out_ready       (rsp_if.ready),
      .out_char        (rsp_if.out_char),
      .out_run_last    (rsp_if.run_last),
      .out_message_end (rsp_if.message_end)
   );

endmodule
